FILE: rtl/core/vsl_pkg.sv
`timescale 1ns / 1ps

package vsl_pkg;

  // Field and arithmetic widths.
  localparam int VEL_WIDTH   = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int RATE_WIDTH  = 16;
  localparam int FRAC_BITS   = 10;
  localparam int STEP_WIDTH  = VEL_WIDTH + 1;
  localparam int SUM_WIDTH   = VEL_WIDTH + 3;
  localparam int PROD_WIDTH  = TIME_WIDTH + RATE_WIDTH;
  localparam int SCALED_WIDTH = PROD_WIDTH - FRAC_BITS;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIN_ACCEL_RATE  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIN_DECEL_RATE  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANG_ACCEL_RATE  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANG_DECEL_RATE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_JERK_THRESHOLD  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_SPEED_LIMIT = 3'd5;

  // Reset values: 0.5/s, 1.0/s, 0.5/s, 0.5/s, 0.3 and 0.3 in 1/1024 units.
  localparam logic [RATE_WIDTH-1:0]       LIN_ACCEL_RESET  = 16'd512;
  localparam logic [RATE_WIDTH-1:0]       LIN_DECEL_RESET  = 16'd1024;
  localparam logic [RATE_WIDTH-1:0]       ANG_ACCEL_RESET  = 16'd512;
  localparam logic [RATE_WIDTH-1:0]       ANG_DECEL_RESET  = 16'd512;
  localparam logic signed [VEL_WIDTH-1:0] JERK_RESET       = 16'sd307;
  localparam logic signed [VEL_WIDTH-1:0] LOW_SPEED_RESET  = 16'sd307;

  // Item kinds.
  localparam logic KIND_CLOCK   = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  typedef logic signed [VEL_WIDTH-1:0] vel_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic [STEP_WIDTH-1:0]       step_t;

  typedef struct packed {
    logic                        kind;
    logic [TIME_WIDTH-1:0]       time_now;
    logic signed [VEL_WIDTH-1:0] target_linear;
    logic signed [VEL_WIDTH-1:0] target_angular;
  } in_t;

  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] limited_linear;
    logic signed [VEL_WIDTH-1:0] limited_angular;
  } out_t;

endpackage

FILE: rtl/core/velocity_slew_limiter.sv
`timescale 1ns / 1ps
// A command's input goes to the input register, its result to the result
// register. Clock items produce no result. Throughput: one item per cycle
// unless a command waits on a full result register; the work stage holds one
// 32x16 multiply per rate followed by an add, a compare and a select.
// Reset (synchronous, active high) restores the default rates and thresholds and
// clears the stored times, the last outputs and both valid flags.

module velocity_slew_limiter
  import vsl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_t                        in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_t                       out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Step size for one rate: floor(dt * rate / 1024), capped at 2^VEL_WIDTH.
  // The full product fits, so it never wraps and needs no overflow check.
  function automatic step_t step_of(logic [TIME_WIDTH-1:0] dt,
                                    logic [RATE_WIDTH-1:0] rate);
    logic [PROD_WIDTH-1:0]   prod;
    logic [SCALED_WIDTH-1:0] scaled;
    prod   = PROD_WIDTH'(dt) * PROD_WIDTH'(rate);
    scaled = prod[PROD_WIDTH-1:FRAC_BITS];
    if (scaled > (SCALED_WIDTH'(1) << VEL_WIDTH)) begin
      return {1'b1, {VEL_WIDTH{1'b0}}};
    end
    return scaled[STEP_WIDTH-1:0];
  endfunction

  // Move from last toward target by at most up (rising) or down (falling).
  function automatic sum_t slew(sum_t last, sum_t target, sum_t up, sum_t down);
    if (last < target && last + up < target) begin
      return last + up;
    end
    if (last > target && last - down > target) begin
      return last - down;
    end
    return target;
  endfunction

  // Configuration registers.
  logic [RATE_WIDTH-1:0] lin_accel_rate;
  logic [RATE_WIDTH-1:0] lin_decel_rate;
  logic [RATE_WIDTH-1:0] ang_accel_rate;
  logic [RATE_WIDTH-1:0] ang_decel_rate;
  vel_t                  jerk_threshold;
  vel_t                  low_speed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_accel_rate  <= LIN_ACCEL_RESET;
      lin_decel_rate  <= LIN_DECEL_RESET;
      ang_accel_rate  <= ANG_ACCEL_RESET;
      ang_decel_rate  <= ANG_DECEL_RESET;
      jerk_threshold  <= JERK_RESET;
      low_speed_limit <= LOW_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIN_ACCEL_RATE:  lin_accel_rate  <= cfg_data[RATE_WIDTH-1:0];
        REG_LIN_DECEL_RATE:  lin_decel_rate  <= cfg_data[RATE_WIDTH-1:0];
        REG_ANG_ACCEL_RATE:  ang_accel_rate  <= cfg_data[RATE_WIDTH-1:0];
        REG_ANG_DECEL_RATE:  ang_decel_rate  <= cfg_data[RATE_WIDTH-1:0];
        REG_JERK_THRESHOLD:  jerk_threshold  <= vel_t'(cfg_data[VEL_WIDTH-1:0]);
        REG_LOW_SPEED_LIMIT: low_speed_limit <= vel_t'(cfg_data[VEL_WIDTH-1:0]);
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Input register. An item sits here for the cycle in which it is worked on.
  // Clock items always leave at once; a command leaves when the result
  // register is free or is being emptied in the same cycle, so a waiting
  // result never blocks the next transfer as long as the consumer keeps up.
  logic stage_valid;
  in_t  stage;
  logic out_free;
  logic stage_drain;
  logic cmd_fire;
  logic clk_fire;

  assign out_free    = !out_valid || out_ready;
  assign cmd_fire    = stage_valid && stage.kind == KIND_COMMAND && out_free;
  assign clk_fire    = stage_valid && stage.kind == KIND_CLOCK;
  assign stage_drain = cmd_fire || clk_fire;
  assign in_ready    = !stage_valid || stage_drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  // Timing state. The elapsed time since the last command is kept as a register
  // of its own, so the work stage starts straight at the multipliers. It always
  // equals clock_time - last_cmd_time modulo 2^TIME_WIDTH; a clock that moves
  // backwards therefore yields a huge dt and the step saturates.
  logic [TIME_WIDTH-1:0] clock_time;
  logic [TIME_WIDTH-1:0] last_cmd_time;
  logic [TIME_WIDTH-1:0] dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_time    <= '0;
      last_cmd_time <= '0;
      dt            <= '0;
    end else if (clk_fire) begin
      clock_time <= stage.time_now;
      dt         <= stage.time_now - last_cmd_time;
    end else if (cmd_fire) begin
      last_cmd_time <= clock_time;
      dt            <= '0;
    end
  end

  // Work stage: four step sizes, then one slew decision per channel.
  vel_t  last_linear;
  vel_t  last_angular;
  step_t lin_up;
  step_t lin_down;
  step_t ang_up;
  step_t ang_down;
  sum_t  tl_s;
  sum_t  ta_s;
  sum_t  ll_s;
  sum_t  la_s;
  logic  lin_bypass;
  sum_t  lin_res;
  sum_t  ang_res;
  vel_t  limited_linear_next;
  vel_t  limited_angular_next;

  always_comb begin
    lin_up   = step_of(dt, lin_accel_rate);
    lin_down = step_of(dt, lin_decel_rate);
    ang_up   = step_of(dt, ang_accel_rate);
    ang_down = step_of(dt, ang_decel_rate);

    tl_s = sum_t'(stage.target_linear);
    ta_s = sum_t'(stage.target_angular);
    ll_s = sum_t'(last_linear);
    la_s = sum_t'(last_angular);

    // A change below the jerk threshold (any fall or a small rise) toward a low target skips limiting entirely.
    lin_bypass = (tl_s - ll_s) < sum_t'(jerk_threshold) &&
                 stage.target_linear <= low_speed_limit;

    if (lin_bypass) begin
      lin_res = tl_s;
    end else begin
      lin_res = slew(ll_s, tl_s, sum_t'(lin_up), sum_t'(lin_down));
    end

    // A zero angular target is a stop request and passes at once.
    if (stage.target_angular == '0) begin
      ang_res = '0;
    end else begin
      ang_res = slew(la_s, ta_s, sum_t'(ang_up), sum_t'(ang_down));
    end

    // Results always lie between the last output and the target, both of
    // which are in field range, so dropping the guard bits is exact.
    limited_linear_next  = vel_t'(lin_res[VEL_WIDTH-1:0]);
    limited_angular_next = vel_t'(ang_res[VEL_WIDTH-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_linear  <= '0;
      last_angular <= '0;
    end else if (cmd_fire) begin
      last_linear  <= limited_linear_next;
      last_angular <= limited_angular_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      out_data.limited_linear  <= limited_linear_next;
      out_data.limited_angular <= limited_angular_next;
    end
  end

  // The elapsed-time register tracks the two stored times.
  a_dt_tracks_times: assert property (@(posedge clk) disable iff (rst)
    dt == clock_time - last_cmd_time)
    else $error("elapsed time register out of step with stored times");

  // Every command that leaves the work stage shows up as a result.
  a_cmd_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> out_valid && out_data.limited_linear == last_linear &&
                 out_data.limited_angular == last_angular)
    else $error("command result not loaded or state not updated");

  // A blocked command holds the input side off.
  a_blocked_holds_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage.kind == KIND_COMMAND && out_valid && !out_ready
    |-> !in_ready)
    else $error("input accepted while the work stage is blocked");

  // A zero angular target drives the angular output to zero.
  a_ang_zero_stop: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && stage.target_angular == '0 |=> last_angular == '0)
    else $error("zero angular target did not stop the angular channel");

endmodule
